FILE: rtl/core/bbec_pkg.sv
// Package with the shared constants, types and sequencer states of the box blur core.
package bbec_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_RADIUS  = 3;
    localparam int RING_ROWS   = 2 * MAX_RADIUS + 1;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int BANK_W      = 3;
    localparam int ACC_W       = 14;
    localparam int CNT_W       = 6;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HRAD   = 2'd2;
    localparam logic [1:0] REG_VRAD   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SETUP,
        ST_READ,
        ST_WAIT,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/core/box_blur_edge_clipped_core.sv
// Top level of the edge-clipped RGBA box blur core with its line store and sequencer.
//
// The core takes RGBA pixels in raster order and returns, for every pixel, the
// truncated mean of the in-image pixels in a window of up to seven by seven,
// together with the pixel's column and row. The line store is seven banks of
// 1024 words, one bank per ring row, so one window column of all rows is read
// at once. An input word that completes no window is only written to the
// store. Each result then passes one setup state, one read per window column,
// a wait for the read latency, the bit-serial divider and one output state.
// The line store needs no clearing after reset. A finished result waits in the
// output register while the core goes on with the next one.
module box_blur_edge_clipped_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel_red,
    input  logic [7:0]  s_pixel_green,
    input  logic [7:0]  s_pixel_blue,
    input  logic [7:0]  s_pixel_alpha,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_blur_red,
    output logic [7:0]  m_blur_green,
    output logic [7:0]  m_blur_blue,
    output logic [7:0]  m_blur_alpha,
    output logic [9:0]  m_out_column,
    output logic [11:0] m_out_row,
    output logic        m_last_of_run
);

    // Configuration registers.
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  hrad_reg;
    logic [1:0]  vrad_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd768;
            hrad_reg   <= 2'd1;
            vrad_reg   <= 2'd1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                bbec_pkg::REG_WIDTH:  width_reg  <= pwdata[10:0];
                bbec_pkg::REG_HEIGHT: height_reg <= pwdata[12:0];
                bbec_pkg::REG_HRAD:   hrad_reg   <= pwdata[1:0];
                bbec_pkg::REG_VRAD:   vrad_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bbec_pkg::REG_WIDTH:  prdata = {21'd0, width_reg};
            bbec_pkg::REG_HEIGHT: prdata = {19'd0, height_reg};
            bbec_pkg::REG_HRAD:   prdata = {30'd0, hrad_reg};
            bbec_pkg::REG_VRAD:   prdata = {30'd0, vrad_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // Effective frame size after clamping.
    logic [10:0] w_eff;
    logic [12:0] h_eff;

    always_comb begin
        if (width_reg == 11'd0) begin
            w_eff = 11'd1;
        end else if (width_reg > 11'(bbec_pkg::MAX_WIDTH)) begin
            w_eff = 11'(bbec_pkg::MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == 13'd0) begin
            h_eff = 13'd1;
        end else if (height_reg > 13'(bbec_pkg::MAX_HEIGHT)) begin
            h_eff = 13'(bbec_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // Sequencer and per-word state.
    bbec_pkg::state_t state_reg, state_next;

    logic [9:0]  col_cnt_reg;
    logic [11:0] row_cnt_reg;
    logic [2:0]  row_mod_reg;
    logic [9:0]  cur_c_reg;
    logic [11:0] cur_r_reg;
    logic [2:0]  cur_rmod_reg;
    logic [31:0] pix_reg;
    logic        any_reg;
    logic [9:0]  x0_reg, x1_reg, x_reg;
    logic [11:0] y0_reg, y1_reg, y_reg;
    logic [9:0]  xb_reg, rd_x_reg;
    logic [bbec_pkg::RING_ROWS-1:0] bank_en_reg;
    logic [bbec_pkg::CNT_W-1:0] count_reg;
    logic        rd_pend_reg;
    logic [2:0]  div_bit_reg;
    logic [bbec_pkg::ACC_W-1:0] acc_reg [4];
    logic [7:0]  quo_reg [4];

    logic        s_accept;
    logic [9:0]  c_in;
    logic [11:0] r_in;
    logic [2:0]  rmod_in;
    logic        last_res;

    assign s_ready  = (state_reg == bbec_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign last_res = (x_reg == x1_reg) && (y_reg == y1_reg);

    always_comb begin
        c_in    = ({1'b0, col_cnt_reg} >= w_eff) ? 10'd0 : col_cnt_reg;
        r_in    = ({1'b0, row_cnt_reg} >= h_eff) ? 12'd0 : row_cnt_reg;
        rmod_in = ({1'b0, row_cnt_reg} >= h_eff) ? 3'd0 : row_mod_reg;
    end

    // Output register.
    logic       out_load;
    logic       m_valid_reg;
    logic [7:0] out_ch_reg [4];
    logic [9:0] out_col_reg;
    logic [11:0] out_row_reg;
    logic       out_last_reg;

    assign out_load = (state_reg == bbec_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbec_pkg::ST_IDLE:  if (s_accept) state_next = bbec_pkg::ST_WRITE;
            bbec_pkg::ST_WRITE: state_next = any_reg ? bbec_pkg::ST_SETUP : bbec_pkg::ST_IDLE;
            bbec_pkg::ST_SETUP: state_next = bbec_pkg::ST_READ;
            bbec_pkg::ST_READ:  if (rd_x_reg == xb_reg) state_next = bbec_pkg::ST_WAIT;
            bbec_pkg::ST_WAIT:  state_next = bbec_pkg::ST_DIV;
            bbec_pkg::ST_DIV:   if (div_bit_reg == 3'd0) state_next = bbec_pkg::ST_OUT;
            bbec_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = last_res ? bbec_pkg::ST_IDLE : bbec_pkg::ST_SETUP;
                end
            end
            default: state_next = bbec_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbec_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Position counters and the ranges of results that this word completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= 10'd0;
            row_cnt_reg <= 12'd0;
            row_mod_reg <= 3'd0;
            any_reg     <= 1'b0;
        end else if (s_accept) begin
            if ({1'b0, c_in} + 11'd1 >= w_eff) begin
                col_cnt_reg <= 10'd0;
                if ({1'b0, r_in} + 13'd1 >= h_eff) begin
                    row_cnt_reg <= 12'd0;
                    row_mod_reg <= 3'd0;
                end else begin
                    row_cnt_reg <= r_in + 12'd1;
                    row_mod_reg <= (rmod_in == 3'(bbec_pkg::RING_ROWS - 1)) ?
                                   3'd0 : rmod_in + 3'd1;
                end
            end else begin
                col_cnt_reg <= c_in + 10'd1;
                row_cnt_reg <= r_in;
                row_mod_reg <= rmod_in;
            end
            any_reg <= (({1'b0, r_in} == h_eff - 13'd1) || (r_in >= {10'd0, vrad_reg})) &&
                       (({1'b0, c_in} == w_eff - 11'd1) || (c_in >= {8'd0, hrad_reg}));
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cur_c_reg    <= c_in;
            cur_r_reg    <= r_in;
            cur_rmod_reg <= rmod_in;
            pix_reg      <= {s_pixel_alpha, s_pixel_blue, s_pixel_green, s_pixel_red};
            if ({1'b0, r_in} == h_eff - 13'd1) begin
                y0_reg <= (r_in >= {10'd0, vrad_reg}) ? r_in - {10'd0, vrad_reg} : 12'd0;
                y1_reg <= r_in;
            end else begin
                y0_reg <= r_in - {10'd0, vrad_reg};
                y1_reg <= r_in - {10'd0, vrad_reg};
            end
            if ({1'b0, c_in} == w_eff - 11'd1) begin
                x0_reg <= (c_in >= {8'd0, hrad_reg}) ? c_in - {8'd0, hrad_reg} : 10'd0;
                x1_reg <= c_in;
            end else begin
                x0_reg <= c_in - {8'd0, hrad_reg};
                x1_reg <= c_in - {8'd0, hrad_reg};
            end
        end else if (state_reg == bbec_pkg::ST_WRITE) begin
            x_reg <= x0_reg;
            y_reg <= y0_reg;
        end else if (out_load && !last_res) begin
            if (x_reg == x1_reg) begin
                x_reg <= x0_reg;
                y_reg <= y_reg + 12'd1;
            end else begin
                x_reg <= x_reg + 10'd1;
            end
        end
    end

    // Window of the current result.
    logic [11:0] ya_c, yb_c;
    logic [9:0]  xa_c, xb_c;
    logic [2:0]  d_c, yamod_c, yspan_c, xspan_c, off_c;
    logic [bbec_pkg::RING_ROWS-1:0] bank_en_c;

    always_comb begin
        ya_c = (y_reg >= {10'd0, vrad_reg}) ? y_reg - {10'd0, vrad_reg} : 12'd0;
        yb_c = ({1'b0, y_reg} + {11'd0, vrad_reg} < h_eff) ?
               y_reg + {10'd0, vrad_reg} : 12'(h_eff - 13'd1);
        xa_c = (x_reg >= {8'd0, hrad_reg}) ? x_reg - {8'd0, hrad_reg} : 10'd0;
        xb_c = ({1'b0, x_reg} + {9'd0, hrad_reg} < w_eff) ?
               x_reg + {8'd0, hrad_reg} : 10'(w_eff - 11'd1);
        d_c     = 3'(cur_r_reg - ya_c);
        yamod_c = (cur_rmod_reg >= d_c) ? cur_rmod_reg - d_c :
                  3'(4'(cur_rmod_reg) + 4'(bbec_pkg::RING_ROWS) - 4'(d_c));
        yspan_c = 3'(yb_c - ya_c);
        xspan_c = 3'(xb_c - xa_c);
        for (int b = 0; b < bbec_pkg::RING_ROWS; b++) begin
            off_c = (3'(b) >= yamod_c) ? 3'(b) - yamod_c :
                    3'(4'(b) + 4'(bbec_pkg::RING_ROWS) - 4'(yamod_c));
            bank_en_c[b] = (off_c <= yspan_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bbec_pkg::ST_SETUP) begin
            xb_reg      <= xb_c;
            rd_x_reg    <= xa_c;
            bank_en_reg <= bank_en_c;
            count_reg   <= (bbec_pkg::CNT_W'(yspan_c) + bbec_pkg::CNT_W'(1)) *
                           (bbec_pkg::CNT_W'(xspan_c) + bbec_pkg::CNT_W'(1));
        end else if (state_reg == bbec_pkg::ST_READ) begin
            rd_x_reg <= rd_x_reg + 10'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == bbec_pkg::ST_READ);
        end
    end

    // Line store: one bank per ring row.
    logic [31:0] bank_rd [bbec_pkg::RING_ROWS];

    for (genvar g = 0; g < bbec_pkg::RING_ROWS; g++) begin : g_bank
        bbec_ram #(
            .WIDTH(32),
            .DEPTH(bbec_pkg::MAX_WIDTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   ((state_reg == bbec_pkg::ST_WRITE) && (cur_rmod_reg == 3'(g))),
            .wr_addr (cur_c_reg),
            .wr_data (pix_reg),
            .rd_addr (rd_x_reg),
            .rd_data (bank_rd[g])
        );
    end

    // Column sums of the selected banks, accumulation and bit-serial division.
    logic [10:0] col_sum [4];
    logic [bbec_pkg::ACC_W:0] trial [4];
    logic [bbec_pkg::ACC_W:0] div_shift;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            col_sum[k] = 11'd0;
            for (int b = 0; b < bbec_pkg::RING_ROWS; b++) begin
                if (bank_en_reg[b]) begin
                    col_sum[k] = col_sum[k] + {3'd0, bank_rd[b][8*k +: 8]};
                end
            end
        end
        div_shift = (bbec_pkg::ACC_W + 1)'({9'd0, count_reg} << div_bit_reg);
        for (int k = 0; k < 4; k++) begin
            trial[k] = {1'b0, acc_reg[k]} - div_shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bbec_pkg::ST_SETUP) begin
            div_bit_reg <= 3'd7;
            for (int k = 0; k < 4; k++) begin
                acc_reg[k] <= '0;
                quo_reg[k] <= 8'd0;
            end
        end else if (rd_pend_reg) begin
            for (int k = 0; k < 4; k++) begin
                acc_reg[k] <= acc_reg[k] + {3'd0, col_sum[k]};
            end
        end else if (state_reg == bbec_pkg::ST_DIV) begin
            div_bit_reg <= div_bit_reg - 3'd1;
            for (int k = 0; k < 4; k++) begin
                if (!trial[k][bbec_pkg::ACC_W]) begin
                    acc_reg[k]              <= trial[k][bbec_pkg::ACC_W-1:0];
                    quo_reg[k][div_bit_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int k = 0; k < 4; k++) begin
                out_ch_reg[k] <= quo_reg[k];
            end
            out_col_reg  <= x_reg;
            out_row_reg  <= y_reg;
            out_last_reg <= last_res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_blur_red    = out_ch_reg[0];
    assign m_blur_green  = out_ch_reg[1];
    assign m_blur_blue   = out_ch_reg[2];
    assign m_blur_alpha  = out_ch_reg[3];
    assign m_out_column  = out_col_reg;
    assign m_out_row     = out_row_reg;
    assign m_last_of_run = out_last_reg;

`ifndef NO_ASSERTIONS
    a_accept_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == bbec_pkg::ST_WRITE)
        else $error("Accepted word did not start a store write.");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bbec_pkg::ST_DIV |-> count_reg != '0)
        else $error("Division started with a zero pixel count.");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("Loaded result is not presented.");
`endif

endmodule

FILE: rtl/core/bbec_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bbec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
